// ===== rtl/mpf_pkg.sv =====
// mpf_pkg: shared constants and types of the matrix peak finder
// used by mpf_out, matrix_peak_finder_unit and the bench; no dependencies
package mpf_pkg;

	localparam int DATA_W    = 32;
	localparam int MAX_COLS  = 32;
	localparam int MAX_ROWS  = 32;
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int CCNT_W    = $clog2(MAX_COLS + 1);
	localparam int RCNT_W    = $clog2(MAX_ROWS + 1);
	localparam int CFG_W     = 6;
	localparam int CFG_IDX_W = 1;
	localparam int MIN_COUNT = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

	// one column of the row store: row two above and row above the incoming one
	typedef struct packed {
		logic [DATA_W-1:0] upper;
		logic [DATA_W-1:0] middle;
	} entry_t;

	// requests from the decision stage to the result stage
	typedef struct packed {
		logic                mid_load;
		logic [ROW_W-1:0]    mid_row;
		logic [COL_W-1:0]    mid_col;
		logic                mid_last;
		logic                burst_load;
		logic [MAX_COLS-1:0] burst_flags;
		logic [ROW_W-1:0]    burst_row;
	} res_req_t;

	// status of the result stage seen by the decision stage
	typedef struct packed {
		logic slot_free;
		logic burst_busy;
	} res_stat_t;

endpackage

// ===== rtl/mpf_ram.sv =====
// mpf_ram: generic one-write one-read synchronous ram with registered read
// no dependencies
module mpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/mpf_out.sv =====
// mpf_out: result register and last-row burst scanner of the peak finder
// depends on mpf_pkg
module mpf_out (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mpf_pkg::res_req_t           req,
	output mpf_pkg::res_stat_t          stat,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [mpf_pkg::ROW_W-1:0]   peak_row,
	output logic [mpf_pkg::COL_W-1:0]   peak_col,
	output logic                        last_of_run
);

	logic                         out_valid_q;
	logic [mpf_pkg::ROW_W-1:0]    out_row_q;
	logic [mpf_pkg::COL_W-1:0]    out_col_q;
	logic                         out_last_q;
	logic [mpf_pkg::MAX_COLS-1:0] burst_q;
	logic [mpf_pkg::COL_W-1:0]    bcol_q;
	logic [mpf_pkg::ROW_W-1:0]    brow_q;
	logic                         slot_free;
	logic                         burst_busy;
	logic                         burst_emit;
	logic                         burst_step;

	assign slot_free  = !out_valid_q || out_ready;
	assign burst_busy = |burst_q;
	// flag clear: skip the column, flag set: needs the output slot
	assign burst_emit = burst_busy && burst_q[0] && slot_free;
	assign burst_step = burst_busy && (!burst_q[0] || slot_free);

	assign stat.slot_free  = slot_free;
	assign stat.burst_busy = burst_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (req.mid_load || burst_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.mid_load) begin
			out_row_q  <= req.mid_row;
			out_col_q  <= req.mid_col;
			out_last_q <= req.mid_last;
		end else if (burst_emit) begin
			out_row_q  <= brow_q;
			out_col_q  <= bcol_q;
			out_last_q <= (burst_q[mpf_pkg::MAX_COLS-1:1] == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_q <= '0;
		end else if (req.burst_load) begin
			burst_q <= req.burst_flags;
		end else if (burst_step) begin
			burst_q <= burst_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.burst_load) begin
			bcol_q <= '0;
			brow_q <= req.burst_row;
		end else if (burst_step) begin
			bcol_q <= bcol_q + 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign peak_row    = out_row_q;
	assign peak_col    = out_col_q;
	assign last_of_run = out_last_q;

	a_no_load_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(req.mid_load || req.burst_load) |-> !burst_busy)
		else $error("result load while last-row burst is running");

	a_burst_emits: assert property (@(posedge clk) disable iff (!arst_n)
		burst_emit |=> out_valid_q && out_row_q == $past(brow_q) && out_col_q == $past(bcol_q))
		else $error("burst flag did not reach the result register");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q && $stable(out_row_q) && $stable(out_col_q))
		else $error("held result changed before its transfer");

endmodule

// ===== rtl/matrix_peak_finder_unit.sv =====
// matrix_peak_finder_unit: top level of the streaming four-neighbour peak finder
// depends on mpf_pkg, mpf_ram and mpf_out
//
// usage
//   cell_value transfers in on in_valid/in_ready, row-major, row_count x col_count
//   cells per matrix. a cell is a peak when it is >= each existing up, down, left
//   and right neighbour. each peak leaves as one transfer on out_valid/out_ready
//   carrying peak_row/peak_col; last_of_run marks the final result of an input.
//   a cell of an upper row is decided when the cell below it arrives; last-row
//   peaks go out as a burst after the final cell of the matrix.
//   the output register takes a result as the decision stage passes the cell that
//   decides it. throughput: one cell per cycle without stalls, set by the single
//   read port of the row store (reads run one column ahead of the incoming cell).
//   after the final cell one more cell is taken into the decision stage, then the
//   input is held off while the burst scanner walks the last-row flags, one column
//   per cycle while the output slot is free, up to the highest flagged column.
//   a stalled receiver holds the output register; cells that decide no peak keep
//   flowing, a cell that decides one waits with in_ready low until the result moves.
//   reset: counts at 32 x 32, position at row 0 column 0, no results pending; the
//   row store needs no clearing pass. a configuration write (only when idle)
//   clamps the count to 2..32 and restarts the matrix at row 0 column 0.
module matrix_peak_finder_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [mpf_pkg::CFG_IDX_W-1:0]        cfg_addr,
	input  logic [mpf_pkg::CFG_W-1:0]            cfg_wr_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [mpf_pkg::DATA_W-1:0]    cell_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [mpf_pkg::ROW_W-1:0]            peak_row,
	output logic [mpf_pkg::COL_W-1:0]            peak_col,
	output logic                                 last_of_run
);

	// configuration and position of the next cell
	logic [mpf_pkg::RCNT_W-1:0]   row_cnt_q;
	logic [mpf_pkg::CCNT_W-1:0]   col_cnt_q;
	logic [mpf_pkg::RCNT_W-1:0]   row_cfg;
	logic [mpf_pkg::CCNT_W-1:0]   col_cfg;
	logic [mpf_pkg::ROW_W-1:0]    pos_row_q;
	logic [mpf_pkg::COL_W-1:0]    pos_col_q;
	logic                         lrow_now;
	logic                         lcol_now;

	// decision stage
	logic                         in_accept;
	logic                         s1_valid_q;
	logic                         s1_go;
	logic [mpf_pkg::DATA_W-1:0]   val_s1;
	logic [mpf_pkg::ROW_W-1:0]    row_s1;
	logic [mpf_pkg::COL_W-1:0]    col_s1;
	logic                         lrow_s1;
	logic                         lcol_s1;

	// row store access
	logic [mpf_pkg::COL_W-1:0]    rd_addr;
	mpf_pkg::entry_t              ram_rdata;
	mpf_pkg::entry_t              wr_data;
	mpf_pkg::entry_t              nxt;
	mpf_pkg::entry_t              cur_q;
	logic                         byp_q;
	mpf_pkg::entry_t              byp_data_q;

	// neighbour values and flags
	logic [mpf_pkg::DATA_W-1:0]   mleft_q;
	logic [mpf_pkg::DATA_W-1:0]   cleft_q;
	logic [mpf_pkg::MAX_COLS-1:0] flags_q;
	logic [mpf_pkg::MAX_COLS-1:0] flags_n;
	logic signed [mpf_pkg::DATA_W-1:0] v_sv, x_sv, up_sv, nx_sv, ml_sv, cl_sv;
	logic                         pk;
	logic                         final_s1;

	mpf_pkg::res_req_t            req;
	mpf_pkg::res_stat_t           stat;

	// clamp of written counts to 2..max
	always_comb begin
		if (cfg_wr_data < mpf_pkg::CFG_W'(mpf_pkg::MIN_COUNT)) begin
			row_cfg = mpf_pkg::RCNT_W'(mpf_pkg::MIN_COUNT);
			col_cfg = mpf_pkg::CCNT_W'(mpf_pkg::MIN_COUNT);
		end else begin
			if (cfg_wr_data > mpf_pkg::CFG_W'(mpf_pkg::MAX_ROWS)) begin
				row_cfg = mpf_pkg::RCNT_W'(mpf_pkg::MAX_ROWS);
			end else begin
				row_cfg = mpf_pkg::RCNT_W'(cfg_wr_data);
			end
			if (cfg_wr_data > mpf_pkg::CFG_W'(mpf_pkg::MAX_COLS)) begin
				col_cfg = mpf_pkg::CCNT_W'(mpf_pkg::MAX_COLS);
			end else begin
				col_cfg = mpf_pkg::CCNT_W'(cfg_wr_data);
			end
		end
	end

	assign lrow_now  = (mpf_pkg::RCNT_W'(pos_row_q) + 1'b1) == row_cnt_q;
	assign lcol_now  = (mpf_pkg::CCNT_W'(pos_col_q) + 1'b1) == col_cnt_q;
	assign in_ready  = !s1_valid_q || s1_go;
	assign in_accept = in_valid && in_ready;

	// config writes restart the matrix; otherwise the position follows each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q <= mpf_pkg::RCNT_W'(mpf_pkg::MAX_ROWS);
			col_cnt_q <= mpf_pkg::CCNT_W'(mpf_pkg::MAX_COLS);
			pos_row_q <= '0;
			pos_col_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				mpf_pkg::REG_ROW_COUNT: row_cnt_q <= row_cfg;
				mpf_pkg::REG_COL_COUNT: col_cnt_q <= col_cfg;
				default: ;
			endcase
			pos_row_q <= '0;
			pos_col_q <= '0;
		end else if (in_accept) begin
			if (lcol_now) begin
				pos_col_q <= '0;
				pos_row_q <= lrow_now ? '0 : pos_row_q + 1'b1;
			end else begin
				pos_col_q <= pos_col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			val_s1  <= cell_value;
			row_s1  <= pos_row_q;
			col_s1  <= pos_col_q;
			lrow_s1 <= lrow_now;
			lcol_s1 <= lcol_now;
		end
	end

	// the read runs one column ahead; at the row end it fetches column 0 for the next row
	assign rd_addr = lcol_now ? '0 : pos_col_q + 1'b1;

	mpf_ram #(
		.WIDTH ($bits(mpf_pkg::entry_t)),
		.DEPTH (mpf_pkg::MAX_COLS)
	) u_row_store (
		.clk     (clk),
		.wr_en   (s1_go),
		.wr_addr (col_s1),
		.wr_data (wr_data),
		.rd_en   (in_accept),
		.rd_addr (rd_addr),
		.rd_data (ram_rdata)
	);

	// same-edge write to the column being fetched: forward the written entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (in_accept) begin
			byp_q <= s1_go && (col_s1 == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byp_data_q <= wr_data;
		end
	end

	assign nxt = byp_q ? byp_data_q : ram_rdata;

	// column c of the middle row moves to the upper row, the new cell takes its place
	assign wr_data.upper  = cur_q.middle;
	assign wr_data.middle = val_s1;

	assign v_sv  = $signed(val_s1);
	assign x_sv  = $signed(cur_q.middle);
	assign up_sv = $signed(cur_q.upper);
	assign nx_sv = $signed(nxt.middle);
	assign ml_sv = $signed(mleft_q);
	assign cl_sv = $signed(cleft_q);

	// decide the middle-row cell above the incoming one
	always_comb begin
		pk = (row_s1 != '0) && (v_sv <= x_sv);
		if (row_s1 > mpf_pkg::ROW_W'(1) && up_sv > x_sv) begin
			pk = 1'b0;
		end
		if (col_s1 != '0 && ml_sv > x_sv) begin
			pk = 1'b0;
		end
		if (!lcol_s1 && nx_sv > x_sv) begin
			pk = 1'b0;
		end
	end

	// last-row candidates: left neighbour is settled once the current cell is seen
	always_comb begin
		flags_n = flags_q;
		if (lrow_s1) begin
			if (col_s1 != '0 && cl_sv < v_sv) begin
				flags_n[col_s1 - 1'b1] = 1'b0;
			end
			flags_n[col_s1] = (v_sv >= x_sv) && !(col_s1 != '0 && v_sv < cl_sv);
		end
	end

	assign final_s1 = lrow_s1 && lcol_s1;
	assign s1_go    = s1_valid_q && !stat.burst_busy && (!pk || stat.slot_free);

	always_ff @(posedge clk) begin
		if (s1_go) begin
			cur_q   <= nxt;
			mleft_q <= cur_q.middle;
			cleft_q <= val_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (cfg_wr_en) begin
			flags_q <= '0;
		end else if (s1_go) begin
			flags_q <= final_s1 ? '0 : flags_n;
		end
	end

	assign req.mid_load    = s1_go && pk;
	assign req.mid_row     = row_s1 - 1'b1;
	assign req.mid_col     = col_s1;
	assign req.mid_last    = !final_s1 || (flags_n == '0);
	assign req.burst_load  = s1_go && final_s1;
	assign req.burst_flags = flags_n;
	assign req.burst_row   = row_s1;

	mpf_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.peak_row    (peak_row),
		.peak_col    (peak_col),
		.last_of_run (last_of_run)
	);

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mpf_pkg::CCNT_W'(pos_col_q) < col_cnt_q)
		else $error("column position beyond col_count");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mpf_pkg::RCNT_W'(pos_row_q) < row_cnt_q)
		else $error("row position beyond row_count");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_go) |=> s1_valid_q && $stable(col_s1) && $stable(row_s1))
		else $error("decision stage lost a stalled cell");

endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for matrix_peak_finder_unit; a scoreboard class predicts
// every peak transfer from the accepted cells, plain tasks drive cells and registers
// depends on mpf_pkg and matrix_peak_finder_unit
module tb;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 11;
	localparam int CYCLE_LIMIT   = 1000000;
	// burst scan walks up to 32 flags, plus the output latency, with margin
	localparam int SETTLE_CYCLES = 48;
	localparam int CELL_TARGET   = 460;
	localparam int LONG_HOLD     = 300;
	localparam int MAX_GAP       = 12;
	localparam int MAX_PRINTS    = 30;

	localparam logic signed [mpf_pkg::DATA_W-1:0] VAL_MIN =
		{1'b1, {(mpf_pkg::DATA_W-1){1'b0}}};
	localparam logic signed [mpf_pkg::DATA_W-1:0] VAL_MAX =
		{1'b0, {(mpf_pkg::DATA_W-1){1'b1}}};

	// how the cells of one matrix are filled
	typedef enum int {
		STYLE_TIES,
		STYLE_FULL,
		STYLE_EDGES,
		STYLE_NEAR_LIMITS
	} fill_style_e;

	typedef struct packed {
		logic [mpf_pkg::ROW_W-1:0] row;
		logic [mpf_pkg::COL_W-1:0] col;
		logic                      last;
	} peak_t;

	// predicts the peak stream and checks each output transfer against it
	class PeakScoreboard;
		logic signed [mpf_pkg::DATA_W-1:0] row_two_up [mpf_pkg::MAX_COLS];
		logic signed [mpf_pkg::DATA_W-1:0] row_one_up [mpf_pkg::MAX_COLS];
		logic signed [mpf_pkg::DATA_W-1:0] left_above;
		logic signed [mpf_pkg::DATA_W-1:0] left_here;
		bit                                bottom_flag [mpf_pkg::MAX_COLS];
		int unsigned                       row_pos;
		int unsigned                       col_pos;
		int unsigned                       n_rows;
		int unsigned                       n_cols;
		peak_t                             peaks_due [$];
		int                                mismatches;

		function new();
			for (int j = 0; j < mpf_pkg::MAX_COLS; j++) begin
				row_two_up[j] = '0;
				row_one_up[j] = '0;
			end
			n_rows     = mpf_pkg::MAX_ROWS;
			n_cols     = mpf_pkg::MAX_COLS;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			row_pos    = 0;
			col_pos    = 0;
			left_above = '0;
			left_here  = '0;
			for (int j = 0; j < mpf_pkg::MAX_COLS; j++) bottom_flag[j] = 1'b0;
		endfunction

		function int unsigned clamp_count(logic [mpf_pkg::CFG_W-1:0] raw, int unsigned top);
			if (raw < mpf_pkg::MIN_COUNT) return mpf_pkg::MIN_COUNT;
			if (raw > top) return top;
			return 32'(raw);
		endfunction

		function void write_reg(logic [mpf_pkg::CFG_IDX_W-1:0] idx,
			logic [mpf_pkg::CFG_W-1:0] raw);
			case (idx)
				mpf_pkg::REG_ROW_COUNT: n_rows = clamp_count(raw, mpf_pkg::MAX_ROWS);
				mpf_pkg::REG_COL_COUNT: n_cols = clamp_count(raw, mpf_pkg::MAX_COLS);
				default: ;
			endcase
			restart();
		endfunction

		function peak_t make_peak(int unsigned r, int unsigned c);
			peak_t p;
			p.row  = mpf_pkg::ROW_W'(r);
			p.col  = mpf_pkg::COL_W'(c);
			p.last = 1'b0;
			return p;
		endfunction

		function void note_cell(logic signed [mpf_pkg::DATA_W-1:0] v);
			peak_t                             found [$];
			logic signed [mpf_pkg::DATA_W-1:0] above;
			int unsigned                       r;
			int unsigned                       c;
			bit                                is_peak;
			bit                                cand;
			if (col_pos >= n_cols || col_pos >= mpf_pkg::MAX_COLS || row_pos >= n_rows)
				restart();
			r     = row_pos;
			c     = col_pos;
			above = row_one_up[c];
			// the cell above the incoming one now has all its neighbours
			if (r >= 1) begin
				is_peak = (v <= above);
				if (r >= 2 && row_two_up[c] > above) is_peak = 1'b0;
				if (c >= 1 && left_above > above) is_peak = 1'b0;
				if (c + 1 < n_cols && row_one_up[c + 1] > above) is_peak = 1'b0;
				if (is_peak) found.push_back(make_peak(r - 1, c));
			end
			// last row: candidates wait for their right neighbour
			if (r == n_rows - 1) begin
				cand = (v >= above);
				if (c >= 1) begin
					if (v < left_here) cand = 1'b0;
					if (left_here < v) bottom_flag[c - 1] = 1'b0;
				end
				bottom_flag[c] = cand;
			end
			left_above    = above;
			row_two_up[c] = above;
			row_one_up[c] = v;
			left_here     = v;
			if (c + 1 < n_cols) begin
				col_pos = c + 1;
			end else begin
				col_pos    = 0;
				left_here  = '0;
				left_above = '0;
				if (r + 1 < n_rows) begin
					row_pos = r + 1;
				end else begin
					for (int j = 0; j < n_cols; j++)
						if (bottom_flag[j]) found.push_back(make_peak(n_rows - 1, j));
					restart();
				end
			end
			if (found.size() > 0) found[found.size() - 1].last = 1'b1;
			foreach (found[i]) peaks_due.push_back(found[i]);
		endfunction

		task report(string what);
			if (mismatches < MAX_PRINTS) $display("peak mismatch: %s", what);
			mismatches++;
		endtask

		task check_peak(logic [mpf_pkg::ROW_W-1:0] row, logic [mpf_pkg::COL_W-1:0] col,
			logic last);
			peak_t due;
			if (peaks_due.size() == 0) begin
				report($sformatf("unexpected peak row %0d col %0d", row, col));
				return;
			end
			due = peaks_due.pop_front();
			if (row !== due.row)
				report($sformatf("peak_row %0d, expected %0d", row, due.row));
			if (col !== due.col)
				report($sformatf("peak_col %0d, expected %0d", col, due.col));
			if (last !== due.last)
				report($sformatf("last_of_run %0b, expected %0b at row %0d col %0d",
					last, due.last, due.row, due.col));
		endtask

		function int pending();
			return peaks_due.size();
		endfunction
	endclass

	logic                                 clk;
	logic                                 arst_n;
	logic                                 cfg_wr_en;
	logic [mpf_pkg::CFG_IDX_W-1:0]        cfg_addr;
	logic [mpf_pkg::CFG_W-1:0]            cfg_wr_data;
	logic                                 in_valid;
	logic                                 in_ready;
	logic signed [mpf_pkg::DATA_W-1:0]    cell_value;
	logic                                 out_valid;
	logic                                 out_ready;
	logic [mpf_pkg::ROW_W-1:0]            peak_row;
	logic [mpf_pkg::COL_W-1:0]            peak_col;
	logic                                 last_of_run;

	PeakScoreboard sb;
	int            cells_sent;
	int            tx_max;
	int            rx_max;
	int            holds_asked;

	matrix_peak_finder_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_addr    (cfg_addr),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cell_value  (cell_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.peak_row    (peak_row),
		.peak_col    (peak_col),
		.last_of_run (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// run limit
	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("matrix_peak_finder_unit test failed");
		$finish;
	end

	// output transfers, sampled with the edge that moves them
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_peak(peak_row, peak_col, last_of_run);
	end

	// gap bound for a stretch: none, short or full
	function automatic int pick_gap_max();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 4;
			default: return MAX_GAP;
		endcase
	endfunction

	// receiver: random stall before each transfer, one long hold per request
	initial begin : sink
		int wait_cycles;
		int taken;
		int holds_taken;
		taken       = 0;
		holds_taken = 0;
		rx_max      = MAX_GAP;
		out_ready   = 1'b0;
		@(posedge arst_n);
		forever begin
			if (holds_asked > holds_taken) begin
				wait_cycles = LONG_HOLD;
				holds_taken++;
			end else begin
				wait_cycles = $urandom_range(0, rx_max);
			end
			if (wait_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
			if (taken % 40 == 0) rx_max = pick_gap_max();
		end
	end

	function automatic logic signed [mpf_pkg::DATA_W-1:0] fill_value(fill_style_e style);
		logic signed [mpf_pkg::DATA_W-1:0] v;
		case (style)
			// narrow range so neighbours tie often
			STYLE_TIES: v = $urandom_range(0, 4) - 2;
			STYLE_EDGES: begin
				case ($urandom_range(0, 4))
					0: v = VAL_MIN;
					1: v = VAL_MAX;
					2: v = '0;
					3: v = -1;
					default: v = $urandom();
				endcase
			end
			STYLE_NEAR_LIMITS: begin
				if ($urandom_range(0, 1)) v = VAL_MAX - $urandom_range(0, 2);
				else v = VAL_MIN + $urandom_range(0, 2);
			end
			default: v = $urandom();
		endcase
		return v;
	endfunction

	// register write, with the block idle
	task automatic program_reg(input logic [mpf_pkg::CFG_IDX_W-1:0] idx,
		input logic [mpf_pkg::CFG_W-1:0] raw);
		cfg_wr_en   <= 1'b1;
		cfg_addr    <= idx;
		cfg_wr_data <= raw;
		@(posedge clk);
		sb.write_reg(idx, raw);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// one cell transfer after a random gap; valid stays up across back-to-back cells
	task automatic send_cell(input logic signed [mpf_pkg::DATA_W-1:0] v);
		int gap;
		gap = $urandom_range(0, tx_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cell_value <= v;
		do @(posedge clk); while (!in_ready);
		sb.note_cell(v);
		cells_sent++;
	endtask

	// stop offering until every predicted peak is out, then let the block go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one setting: register writes, a few whole matrices, maybe a cut-off one
	task automatic run_phase(input logic [mpf_pkg::CFG_W-1:0] rows_raw,
		input logic [mpf_pkg::CFG_W-1:0] cols_raw, input bit cut_short, input bit hold);
		int                            mats;
		int                            cells;
		fill_style_e                   style;
		logic [mpf_pkg::CFG_IDX_W-1:0] junk_idx;
		settle();
		tx_max = hold ? 0 : pick_gap_max();
		// a stray write first, overwritten below
		if ($urandom_range(0, 3) == 0) begin
			junk_idx = $urandom_range(0, 1) ? mpf_pkg::REG_ROW_COUNT : mpf_pkg::REG_COL_COUNT;
			program_reg(junk_idx, mpf_pkg::CFG_W'($urandom_range(0, 63)));
		end
		if ($urandom_range(0, 1)) begin
			program_reg(mpf_pkg::REG_ROW_COUNT, rows_raw);
			program_reg(mpf_pkg::REG_COL_COUNT, cols_raw);
		end else begin
			program_reg(mpf_pkg::REG_COL_COUNT, cols_raw);
			program_reg(mpf_pkg::REG_ROW_COUNT, rows_raw);
		end
		// receiver holds off while the sender keeps offering
		if (hold) holds_asked++;
		cells = int'(sb.n_rows * sb.n_cols);
		mats  = (cells > 40) ? 1 : $urandom_range(1, 3);
		repeat (mats) begin
			style = hold ? STYLE_TIES : fill_style_e'($urandom_range(0, 3));
			repeat (cells) send_cell(fill_value(style));
			// sometimes wait for all peaks before the next matrix
			if ($urandom_range(0, 3) == 0) settle();
		end
		// partial matrix, restarted by the next register write
		if (cut_short) begin
			style = fill_style_e'($urandom_range(0, 3));
			repeat ($urandom_range(1, cells - 1)) send_cell(fill_value(style));
		end
	endtask

	initial begin : stimulus
		int                        phase_no;
		int                        mode;
		logic [mpf_pkg::CFG_W-1:0] rows_raw;
		logic [mpf_pkg::CFG_W-1:0] cols_raw;
		sb          = new();
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_addr    = mpf_pkg::REG_ROW_COUNT;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		cell_value  = '0;
		cells_sent  = 0;
		tx_max      = 0;
		holds_asked = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// counts below the minimum act as two; 2 x 2 of sign extremes
		program_reg(mpf_pkg::REG_ROW_COUNT, mpf_pkg::CFG_W'(1));
		program_reg(mpf_pkg::REG_COL_COUNT, mpf_pkg::CFG_W'(0));
		send_cell(VAL_MIN);
		send_cell(VAL_MAX);
		send_cell(VAL_MAX);
		send_cell(VAL_MIN);
		settle();

		// 3 x 3 of equal values: all ties, every cell is a peak
		program_reg(mpf_pkg::REG_ROW_COUNT, mpf_pkg::CFG_W'(3));
		program_reg(mpf_pkg::REG_COL_COUNT, mpf_pkg::CFG_W'(3));
		tx_max = MAX_GAP;
		repeat (9) send_cell(7);
		settle();

		// 2 x 4 with extremes next to zero and minus one
		program_reg(mpf_pkg::REG_ROW_COUNT, mpf_pkg::CFG_W'(2));
		program_reg(mpf_pkg::REG_COL_COUNT, mpf_pkg::CFG_W'(4));
		send_cell(0);
		send_cell(-1);
		send_cell(VAL_MAX);
		send_cell(VAL_MIN);
		send_cell(VAL_MIN);
		send_cell(VAL_MAX);
		send_cell(-1);
		send_cell(0);

		// tallest and widest shapes, counts above the maximum clamp to it
		run_phase(mpf_pkg::CFG_W'(63), mpf_pkg::CFG_W'(2), 1'b0, 1'b1);
		run_phase(mpf_pkg::CFG_W'(2), mpf_pkg::CFG_W'(32), 1'b0, 1'b0);

		phase_no = 0;
		while (cells_sent < CELL_TARGET) begin
			mode     = $urandom_range(0, 9);
			rows_raw = mpf_pkg::CFG_W'($urandom_range(2, 6));
			cols_raw = mpf_pkg::CFG_W'($urandom_range(2, 6));
			if (mode == 7) begin
				if ($urandom_range(0, 1)) rows_raw = mpf_pkg::CFG_W'($urandom_range(0, 1));
				else cols_raw = mpf_pkg::CFG_W'($urandom_range(0, 1));
			end
			if (mode == 8) begin
				if ($urandom_range(0, 1)) rows_raw = mpf_pkg::CFG_W'($urandom_range(32, 63));
				else cols_raw = mpf_pkg::CFG_W'($urandom_range(32, 63));
			end
			run_phase(rows_raw, cols_raw, (mode == 6 || mode == 9), (phase_no == 5));
			phase_no++;
		end

		settle();
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("matrix_peak_finder_unit test passed");
		end else begin
			$display("matrix_peak_finder_unit test failed");
		end
		$finish;
	end

endmodule

// ===== matrix_peak_finder_unit.f =====
rtl/mpf_pkg.sv
rtl/mpf_ram.sv
rtl/mpf_out.sv
rtl/matrix_peak_finder_unit.sv
tb/tb.sv
